### sv/rpwu_pkg.sv
// Shared types and constants for the RPROP weight update engine.
// Holds the channel payload structs, configuration codes and the
// controller/datapath command and status bundles. No dependencies.
package rpwu_pkg;

  localparam int NUM_WEIGHTS_DEF = 1024;
  localparam int INDEX_W         = 10;
  localparam int DATA_W          = 32;
  localparam int GAIN_W          = 16;
  localparam int GAIN_FRAC       = 14;
  localparam int CFG_INDEX_W     = 2;

  localparam logic [DATA_W-1:0] STEP_INIT = 32'd32768;

  localparam logic [GAIN_W-1:0] GAIN_UP_RST   = 16'd19661;
  localparam logic [GAIN_W-1:0] GAIN_DOWN_RST = 16'd8192;
  localparam logic [DATA_W-1:0] STEP_MIN_RST  = 32'd13;
  localparam logic [DATA_W-1:0] STEP_MAX_RST  = 32'd3276800;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_UPDATE = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAIN_UP   = 2'd0,
    CFG_GAIN_DOWN = 2'd1,
    CFG_STEP_MIN  = 2'd2,
    CFG_STEP_MAX  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t                      command;
    logic [INDEX_W-1:0]       weight_index;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0]       index_out;
    logic signed [DATA_W-1:0] weight_out;
    logic [DATA_W-1:0]        step_out;
  } rsp_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;
    logic reduce;
    logic addr_load;
    logic mem_read;
    logic mul;
    logic update;
    logic commit;
    logic clear;
  } dp_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

### sv/rpwu_ctrl.sv
// Sequencer for the RPROP weight update engine.
// Steps one transaction through the datapath and owns the response valid bit.
// Depends on rpwu_pkg.
module rpwu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output rpwu_pkg::dp_cmd_t   cmd,
  input  rpwu_pkg::dp_status_t status
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_REDUCE = 8'b0000_0100,
    S_ADDR   = 8'b0000_1000,
    S_READ   = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_UPDATE = 8'b0100_0000,
    S_WRITE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;
  logic   rsp_free;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.reduce = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr_load = 1'b1;
        state_next    = S_READ;
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        // hold until the response register is free
        if (rsp_free) begin
          cmd.commit     = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

### sv/rpwu_datapath.sv
// Datapath of the RPROP weight update engine: index reduction, the weight,
// step and previous gradient memories, step scaling and weight saturation.
// Depends on rpwu_pkg.
module rpwu_datapath #(
  parameter int NUM_WEIGHTS = rpwu_pkg::NUM_WEIGHTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rpwu_pkg::dp_cmd_t                   cmd,
  output rpwu_pkg::dp_status_t                status,
  input  rpwu_pkg::req_t                      req_data,
  output rpwu_pkg::rsp_t                      rsp_data,
  input  logic                                cfg_valid,
  input  logic [rpwu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rpwu_pkg::DATA_W-1:0]         cfg_data
);

  localparam int IDX_W     = $clog2(NUM_WEIGHTS);
  localparam int XW        = rpwu_pkg::INDEX_W;
  localparam int DW        = rpwu_pkg::DATA_W;
  localparam int GW        = rpwu_pkg::GAIN_W;
  localparam int MOD_SHIFT = XW + $clog2(NUM_WEIGHTS);
  localparam longint unsigned MOD_RECIP =
    ((64'd1 << MOD_SHIFT) + NUM_WEIGHTS - 1) / NUM_WEIGHTS;
  localparam int QPROD_W   = XW + MOD_SHIFT + 2;
  localparam int NW_W      = $clog2(NUM_WEIGHTS + 1);
  localparam int REM_W     = XW + NW_W;
  localparam int PROD_W    = DW + GW;
  localparam int SCALE_W   = PROD_W - rpwu_pkg::GAIN_FRAC;

  // Configuration registers
  logic [GW-1:0] gain_up;
  logic [GW-1:0] gain_down;
  logic [DW-1:0] step_min;
  logic [DW-1:0] step_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_up   <= rpwu_pkg::GAIN_UP_RST;
      gain_down <= rpwu_pkg::GAIN_DOWN_RST;
      step_min  <= rpwu_pkg::STEP_MIN_RST;
      step_max  <= rpwu_pkg::STEP_MAX_RST;
    end else if (cfg_valid) begin
      unique case (rpwu_pkg::cfg_reg_t'(cfg_index))
        rpwu_pkg::CFG_GAIN_UP:   gain_up   <= cfg_data[GW-1:0];
        rpwu_pkg::CFG_GAIN_DOWN: gain_down <= cfg_data[GW-1:0];
        rpwu_pkg::CFG_STEP_MIN:  step_min  <= cfg_data;
        rpwu_pkg::CFG_STEP_MAX:  step_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured transaction
  rpwu_pkg::op_t          op;
  logic [XW-1:0]          raw_index;
  logic signed [DW-1:0]   grad;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op        <= req_data.command;
      raw_index <= req_data.weight_index;
      grad      <= req_data.value;
    end
  end

  // Index modulo NUM_WEIGHTS: reciprocal multiply, then multiply back and
  // subtract with a single correction.
  logic [QPROD_W-1:0] q_prod;
  logic [XW-1:0]      quot;
  logic [REM_W-1:0]   qn;
  logic [REM_W-1:0]   rem_raw;
  logic [REM_W-1:0]   rem;
  logic [IDX_W-1:0]   addr;
  logic [XW-1:0]      index_out;

  assign q_prod  = QPROD_W'(raw_index) * QPROD_W'(MOD_RECIP);
  assign qn      = REM_W'(quot) * REM_W'(NUM_WEIGHTS);
  assign rem_raw = REM_W'(raw_index) - qn;
  assign rem     = (rem_raw >= REM_W'(NUM_WEIGHTS)) ? rem_raw - REM_W'(NUM_WEIGHTS) : rem_raw;

  always_ff @(posedge clk) begin
    if (cmd.reduce) begin
      quot <= XW'(q_prod >> MOD_SHIFT);
    end
    if (cmd.addr_load) begin
      addr      <= IDX_W'(rem);
      index_out <= XW'(rem);
    end
  end

  // Clearing sweep over the step and previous gradient memories
  logic [IDX_W-1:0] clr_addr;

  assign status.clear_last = (clr_addr == IDX_W'(NUM_WEIGHTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !status.clear_last) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Memories
  logic [DW-1:0] weight_mem [NUM_WEIGHTS];
  logic [DW-1:0] step_mem   [NUM_WEIGHTS];
  logic [DW-1:0] prev_mem   [NUM_WEIGHTS];

  logic [DW-1:0] weight_rd;
  logic [DW-1:0] step_rd;
  logic [DW-1:0] prev_rd;

  logic [DW-1:0]    weight_new;
  logic [DW-1:0]    step_new;
  logic [IDX_W-1:0] wr_addr;
  logic [DW-1:0]    step_wr;
  logic [DW-1:0]    prev_wr;
  logic             state_we;

  assign state_we = cmd.clear || cmd.commit;
  assign wr_addr  = cmd.clear ? clr_addr : addr;
  assign step_wr  = cmd.clear ? rpwu_pkg::STEP_INIT : step_new;
  assign prev_wr  = (cmd.clear || op == rpwu_pkg::CMD_LOAD) ? rpwu_pkg::STEP_INIT
                                                             : grad;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      weight_mem[addr] <= weight_new;
    end
    if (cmd.mem_read) begin
      weight_rd <= weight_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_we) begin
      step_mem[wr_addr] <= step_wr;
    end
    if (cmd.mem_read) begin
      step_rd <= step_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_we) begin
      prev_mem[wr_addr] <= prev_wr;
    end
    if (cmd.mem_read) begin
      prev_rd <= prev_mem[addr];
    end
  end

  // Sign comparison and step scaling product
  logic signed [DW-1:0] prev_s;
  logic                 same_sign;
  logic                 diff_sign;
  logic                 grow;
  logic                 shrink;
  logic [PROD_W-1:0]    step_prod;

  assign prev_s    = $signed(prev_rd);
  assign same_sign = (grad > 0 && prev_s > 0) || (grad < 0 && prev_s < 0);
  assign diff_sign = (grad > 0 && prev_s < 0) || (grad < 0 && prev_s > 0);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      grow      <= same_sign;
      shrink    <= diff_sign;
      step_prod <= PROD_W'(step_rd) * PROD_W'(same_sign ? gain_up : gain_down);
    end
  end

  // New step and saturated weight
  logic [SCALE_W-1:0]   scaled;
  logic [SCALE_W-1:0]   shrunk;
  logic [DW-1:0]        step_calc;
  logic signed [DW+1:0] w_sum;
  logic [DW-1:0]        w_sat;

  assign scaled = SCALE_W'(step_prod >> rpwu_pkg::GAIN_FRAC);
  assign shrunk = (scaled > SCALE_W'(step_min)) ? scaled : SCALE_W'(step_min);

  always_comb begin
    priority if (grow) begin
      step_calc = (scaled < SCALE_W'(step_max)) ? DW'(scaled) : step_max;
    end else if (shrink) begin
      step_calc = (shrunk[SCALE_W-1:DW] != '0) ? '1 : DW'(shrunk);
    end else begin
      step_calc = step_rd;
    end
  end

  always_comb begin
    if (grad > 0) begin
      w_sum = (DW+2)'($signed(weight_rd)) + $signed({2'b00, step_calc});
    end else begin
      w_sum = (DW+2)'($signed(weight_rd)) - $signed({2'b00, step_calc});
    end
    if (w_sum > $signed({3'b000, {(DW-1){1'b1}}})) begin
      w_sat = {1'b0, {(DW-1){1'b1}}};
    end else if (w_sum < $signed({3'b111, {(DW-1){1'b0}}})) begin
      w_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      w_sat = DW'(w_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (op == rpwu_pkg::CMD_LOAD) begin
        weight_new <= grad;
        step_new   <= rpwu_pkg::STEP_INIT;
      end else begin
        weight_new <= w_sat;
        step_new   <= step_calc;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_data.index_out  <= index_out;
      rsp_data.weight_out <= weight_new;
      rsp_data.step_out   <= step_new;
    end
  end

endmodule

### sv/rprop_weight_update.sv
// RPROP weight update engine. One transaction at a time: the sequencer walks
// index reduction, memory read, step multiply, update and write-back for one
// transaction before it takes the next request. After reset a clearing pass
// over all NUM_WEIGHTS entries sets every step and previous gradient to 0.5
// before the first request is taken; configuration writes are taken throughout.
module rprop_weight_update #(
  parameter int NUM_WEIGHTS = rpwu_pkg::NUM_WEIGHTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             req_valid,
  output logic                             req_ready,
  input  rpwu_pkg::req_t                   req_data,
  // response channel
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output rpwu_pkg::rsp_t                   rsp_data,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rpwu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rpwu_pkg::DATA_W-1:0]      cfg_data
);

  rpwu_pkg::dp_cmd_t    cmd;
  rpwu_pkg::dp_status_t status;

  // Registers are plain flops: accept a configuration transaction every cycle.
  assign cfg_ready = 1'b1;

  // Sequencer: clear sweep, then one transaction through the datapath at a
  // time; the response register frees the request side while a result waits.
  rpwu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath: index modulo, memories, step scaling and weight saturation.
  rpwu_datapath #(
    .NUM_WEIGHTS (NUM_WEIGHTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_data  (req_data),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

### verif/rprop_weight_update_tb.sv
// Self-checking testbench for rprop_weight_update: drives load and gradient
// transactions plus register writes, and checks every response in order.
// Depends on rpwu_pkg (payload structs, command and register codes, resets).
`timescale 1ns / 100ps

module rprop_weight_update_tb;
  import rpwu_pkg::*;

  localparam int     CLK_PERIOD = 12;
  localparam int     N_WEIGHTS  = NUM_WEIGHTS_DEF;
  localparam int     HOT_DEPTH  = 6;
  localparam longint WEIGHT_MAX = 64'sd2147483647;
  localparam longint WEIGHT_MIN = -64'sd2147483648;
  localparam longint STEP_CEIL  = 64'sh0000_0000_FFFF_FFFF;

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_ready;
  req_t                   req_data;
  logic                   rsp_valid;
  logic                   rsp_ready;
  rsp_t                   rsp_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DATA_W-1:0]      cfg_data;

  rprop_weight_update #(
    .NUM_WEIGHTS(N_WEIGHTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the per-weight state and the four registers
  logic [DATA_W-1:0] weight_mem    [N_WEIGHTS];
  logic [DATA_W-1:0] step_mem      [N_WEIGHTS];
  logic [DATA_W-1:0] last_grad_mem [N_WEIGHTS];
  logic [GAIN_W-1:0] gain_up_q;
  logic [GAIN_W-1:0] gain_down_q;
  logic [DATA_W-1:0] step_min_q;
  logic [DATA_W-1:0] step_max_q;

  // Which weights hold a loaded value; updates only ever target these, since
  // the weight of an entry that was never loaded is undefined.
  bit          loaded [N_WEIGHTS];
  int unsigned loaded_list[$];
  // Recently loaded entries: most updates land here, so that steps run into
  // their caps and floors and the same entry comes back to back.
  int unsigned recent_idx[$];

  rsp_t expected_rsp[$];
  int   error_count = 0;
  bit   steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #(200_000 * CLK_PERIOD);
    $display("Simulation FAILED");
    $finish;
  end

  // Roll for an idle cycle on either channel; none while a steady stretch runs
  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < 7);
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Work out the response of one transaction and advance the shadow state.
  // Step scaling is done at full width, then capped on growth or floored on
  // shrink; a shrink factor above one can push the step past 32 bits, which
  // clips to all ones. A zero gradient leaves the step alone but still moves
  // the weight down.
  function automatic rsp_t predict_rprop(req_t it);
    int unsigned idx;
    longint      grad;
    longint      prev;
    longint      stp;
    longint      prod;
    longint      wgt;
    rsp_t        r;
    idx = it.weight_index % N_WEIGHTS;
    if (it.command == CMD_LOAD) begin
      weight_mem[idx]    = it.value;
      step_mem[idx]      = STEP_INIT;
      last_grad_mem[idx] = STEP_INIT;
    end else begin
      grad = $signed(it.value);
      prev = $signed(last_grad_mem[idx]);
      stp  = step_mem[idx];
      if ((grad > 0 && prev > 0) || (grad < 0 && prev < 0)) begin
        prod = (stp * gain_up_q) >> GAIN_FRAC;
        stp  = (prod < step_max_q) ? prod : step_max_q;
      end else if ((grad > 0 && prev < 0) || (grad < 0 && prev > 0)) begin
        prod = (stp * gain_down_q) >> GAIN_FRAC;
        stp  = (prod > step_min_q) ? prod : step_min_q;
        if (stp > STEP_CEIL)
          stp = STEP_CEIL;
      end
      step_mem[idx]      = 32'(stp);
      last_grad_mem[idx] = it.value;
      wgt = $signed(weight_mem[idx]);
      if (grad > 0)
        wgt = wgt + stp;
      else
        wgt = wgt - stp;
      if (wgt > WEIGHT_MAX)
        wgt = WEIGHT_MAX;
      if (wgt < WEIGHT_MIN)
        wgt = WEIGHT_MIN;
      weight_mem[idx] = 32'(wgt);
    end
    r.index_out  = INDEX_W'(idx);
    r.weight_out = weight_mem[idx];
    r.step_out   = step_mem[idx];
    return r;
  endfunction

  function automatic req_t make_req(op_t c, int unsigned idx, logic [DATA_W-1:0] v);
    req_t it;
    it.command      = c;
    it.weight_index = INDEX_W'(idx);
    it.value        = v;
    return it;
  endfunction

  // Random transaction: mostly updates on recently loaded entries, with the
  // gradient sign biased towards repeating the last one so steps keep growing.
  function automatic req_t next_item();
    int unsigned       idx;
    int unsigned       r;
    logic [DATA_W-1:0] v;
    bit                neg;
    r = $urandom_range(99);
    if (loaded_list.size() == 0 || r < 12) begin
      if (recent_idx.size() != 0 && $urandom_range(1) == 1)
        idx = recent_idx[$urandom_range(recent_idx.size() - 1)];
      else
        idx = $urandom_range(N_WEIGHTS - 1);
      case ($urandom_range(9))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = 32'h7FF0_0000 + $urandom_range(20'hF_FFFF);
        3: v = 32'h8000_0000 + $urandom_range(20'hF_FFFF);
        default: v = $urandom;
      endcase
      return make_req(CMD_LOAD, idx, v);
    end
    if (recent_idx.size() != 0 && $urandom_range(9) < 8)
      idx = recent_idx[$urandom_range(recent_idx.size() - 1)];
    else
      idx = loaded_list[$urandom_range(loaded_list.size() - 1)];
    neg = last_grad_mem[idx][DATA_W-1] ^ ($urandom_range(99) < 30);
    case ($urandom_range(19))
      0, 1: v = '0;
      2:    v = 32'h7FFF_FFFF;
      3:    v = 32'h8000_0000;
      4:    v = neg ? 32'hFFFF_FFFF : 32'd1;
      default: begin
        v = $urandom;
        v[DATA_W-1] = neg;
        if (v == '0)
          v = 32'd1;
      end
    endcase
    return make_req(CMD_UPDATE, idx, v);
  endfunction

  // Offer one transaction, hold it until accepted, then queue its prediction.
  // Valid stays high on return so that the next transaction can follow at once.
  task automatic send_req(req_t it);
    int unsigned idx;
    while (idle_roll()) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= it;
    do @(posedge clk); while (req_ready !== 1'b1);
    expected_rsp = {expected_rsp, predict_rprop(it)};
    if (it.command == CMD_LOAD) begin
      idx = it.weight_index % N_WEIGHTS;
      if (!loaded[idx]) begin
        loaded[idx] = 1'b1;
        loaded_list = {loaded_list, idx};
      end
      recent_idx = {recent_idx, idx};
      if (recent_idx.size() > HOT_DEPTH)
        void'(recent_idx.pop_front());
    end
  endtask

  task automatic send_random(int n);
    repeat (n) send_req(next_item());
  endtask

  // Drop valid and wait until every queued response has come back
  task automatic wait_all_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_rsp.size() != 0);
  endtask

  // Write all four registers while the engine is idle
  task automatic apply_settings(logic [GAIN_W-1:0] gu, logic [GAIN_W-1:0] gd,
                                logic [DATA_W-1:0] smin, logic [DATA_W-1:0] smax);
    cfg_reg_t          regs [4];
    logic [DATA_W-1:0] vals [4];
    regs = '{CFG_GAIN_UP, CFG_GAIN_DOWN, CFG_STEP_MIN, CFG_STEP_MAX};
    vals = '{DATA_W'(gu), DATA_W'(gd), smin, smax};
    wait_all_responses();
    for (int k = 0; k < 4; k++) begin
      while (idle_roll()) begin
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      case (regs[k])
        CFG_GAIN_UP:   gain_up_q   = vals[k][GAIN_W-1:0];
        CFG_GAIN_DOWN: gain_down_q = vals[k][GAIN_W-1:0];
        CFG_STEP_MIN:  step_min_q  = vals[k];
        CFG_STEP_MAX:  step_max_q  = vals[k];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Loads at the field extremes, then growth, shrink, zero gradient,
  // saturation at both ends, a reload, and repeated hits on one entry.
  task automatic test_directed_cases();
    send_req(make_req(CMD_LOAD,   0,    32'h0000_0000));
    send_req(make_req(CMD_LOAD,   1023, 32'h7FFF_FFFF));
    send_req(make_req(CMD_LOAD,   512,  32'h8000_0000));
    send_req(make_req(CMD_LOAD,   1,    32'hFFFF_FFFF));
    send_req(make_req(CMD_UPDATE, 0,    32'h0000_0001));
    send_req(make_req(CMD_UPDATE, 0,    32'h7FFF_FFFF));
    send_req(make_req(CMD_UPDATE, 0,    32'hFFFF_FFFF));
    send_req(make_req(CMD_UPDATE, 0,    32'h0000_0000));
    send_req(make_req(CMD_UPDATE, 0,    32'h8000_0000));
    send_req(make_req(CMD_UPDATE, 1023, 32'h0001_0000));
    send_req(make_req(CMD_UPDATE, 512,  32'hFFFF_FFFB));
    send_req(make_req(CMD_UPDATE, 1,    32'hFFFF_FFFF));
    send_req(make_req(CMD_LOAD,   1,    32'd12345));
    send_req(make_req(CMD_UPDATE, 1,    32'h4000_0000));
    send_req(make_req(CMD_LOAD,   2,    32'h0002_0000));
    send_req(make_req(CMD_UPDATE, 2,    32'h0000_0100));
    send_req(make_req(CMD_UPDATE, 2,    32'h0000_0200));
    send_req(make_req(CMD_UPDATE, 2,    32'hFFFF_0000));
    wait_all_responses();
  endtask

  // Registers at their extremes, including a shrink factor above one that
  // drives the step past 32 bits
  task automatic test_register_extremes();
    apply_settings(16'hFFFF, 16'hFFFF, 32'h0, 32'hFFFF_FFFF);
    send_req(make_req(CMD_LOAD, 7, 32'h0));
    repeat (12) send_req(make_req(CMD_UPDATE, 7, 32'h0000_0100));
    repeat (2) begin
      send_req(make_req(CMD_UPDATE, 7, 32'hFFFF_FFFF));
      send_req(make_req(CMD_UPDATE, 7, 32'h0000_0001));
    end
    send_random(30);
    apply_settings(16'h0, 16'h0, 32'h0, 32'h0);
    send_random(30);
    apply_settings(16'h0, 16'h0, 32'hFFFF_FFFF, 32'h0);
    send_random(30);
    apply_settings(16'hFFFF, 16'h0, STEP_MIN_RST, STEP_MAX_RST);
    send_random(30);
    wait_all_responses();
  endtask

  task automatic test_random_settings();
    logic [DATA_W-1:0] smax;
    repeat (5) begin
      smax = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 16, 1 << 24);
      apply_settings(GAIN_W'($urandom_range(16'hFFFF)), GAIN_W'($urandom_range(16'hFFFF)),
                     $urandom_range(0, 1 << 16), smax);
      send_random(40);
    end
    wait_all_responses();
  endtask

  task automatic test_random_traffic();
    apply_settings(GAIN_UP_RST, GAIN_DOWN_RST, STEP_MIN_RST, STEP_MAX_RST);
    send_random(220);
    wait_all_responses();
  endtask

  // Long stretch with both sides always ready
  task automatic test_no_idle();
    steady = 1'b1;
    send_random(80);
    wait_all_responses();
    steady = 1'b0;
  endtask

  // Response side: stall at random, compare each accepted transaction with
  // the oldest prediction
  initial begin : response_checker
    rsp_t want;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
        if (expected_rsp.size() == 0) begin
          flag_error($sformatf("response with none pending, index %0d", rsp_data.index_out));
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_data.index_out !== want.index_out)
            flag_error($sformatf("index_out got %0d want %0d",
                                 rsp_data.index_out, want.index_out));
          if (rsp_data.weight_out !== want.weight_out)
            flag_error($sformatf("index %0d weight_out got %h want %h",
                                 want.index_out, rsp_data.weight_out, want.weight_out));
          if (rsp_data.step_out !== want.step_out)
            flag_error($sformatf("index %0d step_out got %h want %h",
                                 want.index_out, rsp_data.step_out, want.step_out));
        end
      end
      rsp_ready <= !idle_roll();
    end
  end

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_data  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_GAIN_UP;
    cfg_data  <= '0;
    gain_up_q   = GAIN_UP_RST;
    gain_down_q = GAIN_DOWN_RST;
    step_min_q  = STEP_MIN_RST;
    step_max_q  = STEP_MAX_RST;
    foreach (step_mem[i]) begin
      weight_mem[i]    = '0;
      step_mem[i]      = STEP_INIT;
      last_grad_mem[i] = STEP_INIT;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // The engine clears its stores after reset; the first send simply waits
    // for ready
    test_directed_cases();
    test_register_extremes();
    test_random_settings();
    test_random_traffic();
    test_no_idle();

    wait_all_responses();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### rprop_weight_update.f
sv/rpwu_pkg.sv
sv/rpwu_ctrl.sv
sv/rpwu_datapath.sv
sv/rprop_weight_update.sv
verif/rprop_weight_update_tb.sv
